// File: src/dbws_pkg.sv
// Shared types and constants of the delay-based window sender.
// Depends on nothing; used by every other file of the block.
`default_nettype none

package dbws_pkg;

	// Widths of the datapath
	localparam int unsigned CFG_W   = 34;  // widest configuration register
	localparam int unsigned CNT_W   = 7;   // burst count, holds up to 127
	localparam int unsigned QDEPTH  = 2;   // job queue entries

	localparam int unsigned MAX_BURST_DEF = 64;

	// Register map
	typedef enum logic [2:0] {
		REG_LOWER_RTT    = 3'd0,
		REG_UPPER_RTT    = 3'd1,
		REG_LOWER_WINDOW = 3'd2,
		REG_UPPER_WINDOW = 3'd3,
		REG_INTERVAL     = 3'd4,
		REG_OWN_ID       = 3'd5,
		REG_SERVER_MODE  = 3'd6,
		REG_REMOTE_KNOWN = 3'd7
	} reg_idx_t;

	// Input opcodes
	localparam logic OP_ACK  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_ACK       = 3'd0,
		KIND_STRAY     = 3'd1,
		KIND_OTHER     = 3'd2,
		KIND_DATA      = 3'd3,
		KIND_IDLE_TICK = 3'd4
	} kind_t;

	// Reset values of the registers and the state
	localparam logic [33:0] LOWER_RTT_RST    = 34'd50000000;
	localparam logic [33:0] UPPER_RTT_RST    = 34'd100000000;
	localparam logic [15:0] LOWER_WINDOW_RST = 16'd50;
	localparam logic [15:0] UPPER_WINDOW_RST = 16'd1000;
	localparam logic [29:0] INTERVAL_RST     = 30'd1000000;

	localparam logic [29:0] WAIT_MAX    = 30'd1000000000;
	localparam logic [15:0] SHRINK_STEP = 16'd20;
	localparam logic [16:0] GUARD_STEP  = 17'd10;

	// One job handed from the classifier to the emitter
	typedef struct packed {
		kind_t              kind;
		logic [CNT_W-1:0]   count;      // results to emit, at least one
		logic [30:0]        seq_start;
		logic [62:0]        pkt_stamp;
		logic [15:0]        window;
		logic [31:0]        max_ack;
		logic [29:0]        wait_ns;
		logic               roam;
		logic [16:0]        foreign;
	} job_t;

endpackage

`default_nettype wire

// File: src/dbws_front.sv
// Front end: configuration registers, sender state, item classification.
// Turns each accepted ack or tick into one job. Depends on dbws_pkg.
`default_nettype none

module dbws_front #(
	parameter int unsigned MAX_BURST = dbws_pkg::MAX_BURST_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          opcode,
	input  wire  [62:0]                  now_ns,
	input  wire  signed [31:0]           packet_sequence,
	input  wire  [15:0]                  packet_sender,
	input  wire  signed [31:0]           acked_number,
	input  wire  [62:0]                  echoed_send_time_ns,
	input  wire                          cfg_we,
	input  wire  [2:0]                   cfg_idx,
	input  wire  [dbws_pkg::CFG_W-1:0]   cfg_data,
	output logic                         job_valid,
	input  wire                          job_ready,
	output dbws_pkg::job_t               job
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_UPDATE,
		ST_SETTLE,
		ST_PUSH
	} state_t;

	state_t state_q;

	// Configuration
	logic [33:0] lower_rtt_q, upper_rtt_q;
	logic [15:0] lower_window_q, upper_window_q, own_id_q;
	logic [29:0] interval_q;
	logic        server_q, remote_q;

	// Sender state
	logic [15:0]        window_q;
	logic [31:0]        packets_sent_q;
	logic [31:0]        max_ack_q;
	logic signed [16:0] foreign_q;
	logic [63:0]        next_send_q;

	// Captured item
	logic        op_q;
	logic [62:0] now_q, echo_q;
	logic [31:0] pseq_q, acked_q;
	logic [15:0] sender_q;

	// Intermediate results
	logic signed [63:0]        rtt_q;
	logic [31:0]               outs_q;
	logic [63:0]               cand_q;
	logic                      late_q;
	logic                      roam_q;
	logic                      own_ack_q;
	dbws_pkg::kind_t           kind_q;
	logic [dbws_pkg::CNT_W-1:0] cnt_q;
	logic [31:0]               seq_start_q;
	logic [63:0]               diff_q;
	logic                      due_q;

	logic [63:0]                now64;
	logic                       is_ack, is_own, fill, grow, shrink, after_full;
	logic [32:0]                amount;
	logic [dbws_pkg::CNT_W-1:0] burst;
	logic [15:0]                window_shrunk;
	logic [29:0]                wait_c;

	assign now64  = {1'b0, now_q};
	assign is_ack = (pseq_q == 32'hFFFF_FFFF);
	assign is_own = (sender_q == own_id_q);

	// Window fill decision and burst size
	assign fill   = $signed({outs_q[31], outs_q}) < $signed({17'd0, window_q});
	assign amount = {17'd0, window_q} - {outs_q[31], outs_q};
	assign burst  = (amount > 33'(MAX_BURST)) ? dbws_pkg::CNT_W'(MAX_BURST)
	                                          : amount[dbws_pkg::CNT_W-1:0];

	// Window grow and shrink rules
	assign grow   = (rtt_q < $signed({30'd0, lower_rtt_q})) && (window_q < upper_window_q);
	assign shrink = (rtt_q > $signed({30'd0, upper_rtt_q}))
	             && ({1'b0, window_q} > ({1'b0, lower_window_q} + dbws_pkg::GUARD_STEP));
	assign window_shrunk = (window_q > dbws_pkg::SHRINK_STEP)
	                     ? window_q - dbws_pkg::SHRINK_STEP : 16'd0;

	// Wait time, from the state left by the tick
	assign after_full = !($signed({outs_q[31], outs_q}) < $signed({17'd0, window_q}));
	always_comb begin
		if (op_q == dbws_pkg::OP_ACK) begin
			wait_c = '0;
		end else if (!remote_q) begin
			wait_c = dbws_pkg::WAIT_MAX;
		end else if (!after_full || due_q) begin
			wait_c = '0;
		end else if (diff_q > {34'd0, dbws_pkg::WAIT_MAX}) begin
			wait_c = dbws_pkg::WAIT_MAX;
		end else begin
			wait_c = diff_q[29:0];
		end
	end

	// Job toward the queue
	assign in_ready  = (state_q == ST_IDLE);
	assign job_valid = (state_q == ST_PUSH);
	always_comb begin
		job.kind      = kind_q;
		job.count     = cnt_q;
		job.seq_start = seq_start_q[30:0];
		job.pkt_stamp = (kind_q == dbws_pkg::KIND_DATA) ? now_q : 63'd0;
		job.window    = window_q;
		job.max_ack   = max_ack_q;
		job.wait_ns   = wait_c;
		job.roam      = roam_q;
		job.foreign   = foreign_q;
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= opcode;
			now_q    <= now_ns;
			pseq_q   <= packet_sequence;
			sender_q <= packet_sender;
			acked_q  <= acked_number;
			echo_q   <= echoed_send_time_ns;
		end
	end

	// Sequencer, state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			lower_rtt_q    <= dbws_pkg::LOWER_RTT_RST;
			upper_rtt_q    <= dbws_pkg::UPPER_RTT_RST;
			lower_window_q <= dbws_pkg::LOWER_WINDOW_RST;
			upper_window_q <= dbws_pkg::UPPER_WINDOW_RST;
			interval_q     <= dbws_pkg::INTERVAL_RST;
			own_id_q       <= '0;
			server_q       <= 1'b0;
			remote_q       <= 1'b0;
			window_q       <= dbws_pkg::LOWER_WINDOW_RST;
			packets_sent_q <= '0;
			max_ack_q      <= '1;
			foreign_q      <= '1;
			next_send_q    <= '0;
			rtt_q          <= '0;
			outs_q         <= '0;
			cand_q         <= '0;
			late_q         <= 1'b0;
			roam_q         <= 1'b0;
			own_ack_q      <= 1'b0;
			kind_q         <= dbws_pkg::KIND_IDLE_TICK;
			cnt_q          <= '0;
			seq_start_q    <= '0;
			diff_q         <= '0;
			due_q          <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				// Round trip, outstanding count, next deadline, roam check
				ST_EVAL: begin
					rtt_q  <= $signed(now64 - {1'b0, echo_q});
					outs_q <= packets_sent_q - max_ack_q - 32'd1;
					cand_q <= now64 + {34'd0, interval_q};
					late_q <= (next_send_q < now64);
					roam_q <= 1'b0;
					if (op_q == dbws_pkg::OP_ACK && is_ack && server_q
					    && ($signed({1'b0, sender_q}) > foreign_q)) begin
						foreign_q <= $signed({1'b0, sender_q});
						roam_q    <= 1'b1;
					end
					state_q <= ST_UPDATE;
				end
				// Apply the ack, or size the burst of the tick
				ST_UPDATE: begin
					cnt_q       <= dbws_pkg::CNT_W'(1);
					seq_start_q <= '0;
					own_ack_q   <= 1'b0;
					if (op_q == dbws_pkg::OP_ACK) begin
						if (!is_ack) begin
							kind_q <= dbws_pkg::KIND_STRAY;
						end else if (!is_own) begin
							kind_q <= dbws_pkg::KIND_OTHER;
						end else begin
							kind_q    <= dbws_pkg::KIND_ACK;
							own_ack_q <= 1'b1;
							if ($signed(acked_q) > $signed(max_ack_q)) begin
								max_ack_q <= acked_q;
							end
							if (grow) begin
								window_q <= window_q + 16'd1;
							end
						end
					end else if (!remote_q) begin
						kind_q <= dbws_pkg::KIND_IDLE_TICK;
					end else if (fill) begin
						kind_q         <= dbws_pkg::KIND_DATA;
						cnt_q          <= burst;
						seq_start_q    <= packets_sent_q;
						packets_sent_q <= packets_sent_q + 32'(burst);
						next_send_q    <= cand_q;
					end else if (late_q) begin
						kind_q         <= dbws_pkg::KIND_DATA;
						seq_start_q    <= packets_sent_q;
						packets_sent_q <= packets_sent_q + 32'd1;
						next_send_q    <= cand_q;
					end else begin
						kind_q <= dbws_pkg::KIND_IDLE_TICK;
					end
					state_q <= ST_SETTLE;
				end
				// Shrink after grow; prepare the wait time
				ST_SETTLE: begin
					if (own_ack_q && shrink) begin
						window_q <= window_shrunk;
					end
					outs_q  <= packets_sent_q - max_ack_q - 32'd1;
					diff_q  <= next_send_q - now64;
					due_q   <= (next_send_q <= now64);
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (job_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// The user must write registers only while the block is idle; the block itself does not enforce it
			if (cfg_we) begin
				case (cfg_idx)
					dbws_pkg::REG_LOWER_RTT:    lower_rtt_q <= cfg_data[33:0];
					dbws_pkg::REG_UPPER_RTT:    upper_rtt_q <= cfg_data[33:0];
					dbws_pkg::REG_LOWER_WINDOW: begin
						lower_window_q <= cfg_data[15:0];
						window_q       <= cfg_data[15:0];
					end
					dbws_pkg::REG_UPPER_WINDOW: upper_window_q <= cfg_data[15:0];
					dbws_pkg::REG_INTERVAL:     interval_q <= cfg_data[29:0];
					dbws_pkg::REG_OWN_ID:       own_id_q <= cfg_data[15:0];
					dbws_pkg::REG_SERVER_MODE:  server_q <= cfg_data[0];
					dbws_pkg::REG_REMOTE_KNOWN: remote_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: src/dbws_fifo.sv
// Short job queue between the classifier and the emitter.
// Depends on dbws_pkg for the job type and depth.
`default_nettype none

module dbws_fifo (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             wr_valid,
	output logic            wr_ready,
	input  dbws_pkg::job_t  wr_data,
	output logic            rd_valid,
	input  wire             rd_ready,
	output dbws_pkg::job_t  rd_data
);

	localparam int unsigned PTR_W = (dbws_pkg::QDEPTH > 1) ? $clog2(dbws_pkg::QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(dbws_pkg::QDEPTH + 1);

	dbws_pkg::job_t mem_q [dbws_pkg::QDEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push, pop;

	assign wr_ready = (fill_q != CNT_W'(dbws_pkg::QDEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(dbws_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(dbws_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/dbws_emit.sv
// Back end: expands one job into its results, one result per cycle
// unless the output stalls, into an output register. Depends on dbws_pkg.
`default_nettype none

module dbws_emit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 job_valid,
	output logic                job_ready,
	input  dbws_pkg::job_t      job,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [2:0]          result_kind,
	output logic [30:0]         out_sequence,
	output logic [62:0]         out_send_time_ns,
	output logic [15:0]         window_now,
	output logic signed [31:0]  highest_ack,
	output logic [29:0]         wait_ns,
	output logic                roam_event,
	output logic signed [16:0]  foreign_sender,
	output logic                last_result
);

	dbws_pkg::job_t             cur_q;
	logic                       busy_q;
	logic [30:0]                seq_q;
	logic [dbws_pkg::CNT_W-1:0] rem_q;
	logic                       emit;

	assign job_ready = !busy_q;
	assign emit      = busy_q && (!out_valid || out_ready);

	// Load a job, then issue its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
			seq_q     <= '0;
			rem_q     <= '0;
		end else begin
			if (!busy_q && job_valid) begin
				busy_q <= 1'b1;
				seq_q  <= job.seq_start;
				rem_q  <= job.count;
			end else if (emit) begin
				seq_q  <= seq_q + 31'd1;
				rem_q  <= rem_q - 1'b1;
				busy_q <= (rem_q != dbws_pkg::CNT_W'(1));
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Job and result payload
	always_ff @(posedge clk) begin
		if (!busy_q && job_valid) begin
			cur_q <= job;
		end
		if (emit) begin
			result_kind      <= cur_q.kind;
			out_sequence     <= seq_q;
			out_send_time_ns <= cur_q.pkt_stamp;
			window_now       <= cur_q.window;
			highest_ack      <= cur_q.max_ack;
			wait_ns          <= cur_q.wait_ns;
			roam_event       <= cur_q.roam;
			foreign_sender   <= cur_q.foreign;
			last_result      <= (rem_q == dbws_pkg::CNT_W'(1));
		end
	end

endmodule

`default_nettype wire

// File: src/delay_based_window_sender_unit.sv
// Top level of the delay-based window sender: front end, job queue, emitter.
// Depends on dbws_pkg, dbws_front, dbws_fifo and dbws_emit.
//
// Each accepted ack or tick passes through the front end in order (accept,
// evaluate, update, settle, hand off); the front end takes no new item until
// it has handed off the last one, and the hand off waits for room in the job
// queue. The emitter then gives one result per cycle while the output is not
// stalled: one for an ack or an idle tick, and up to MAX_BURST data packets
// for a tick. The two-entry queue lets the front end classify the next items
// while a burst is still being sent.
`default_nettype none

module delay_based_window_sender_unit #(
	parameter int unsigned MAX_BURST = dbws_pkg::MAX_BURST_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          opcode,
	input  wire  [62:0]                  now_ns,
	input  wire  signed [31:0]           packet_sequence,
	input  wire  [15:0]                  packet_sender,
	input  wire  signed [31:0]           acked_number,
	input  wire  [62:0]                  echoed_send_time_ns,
	input  wire                          cfg_we,
	input  wire  [2:0]                   cfg_idx,
	input  wire  [dbws_pkg::CFG_W-1:0]   cfg_data,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [2:0]                   result_kind,
	output logic [30:0]                  out_sequence,
	output logic [62:0]                  out_send_time_ns,
	output logic [15:0]                  window_now,
	output logic signed [31:0]           highest_ack,
	output logic [29:0]                  wait_ns,
	output logic                         roam_event,
	output logic signed [16:0]           foreign_sender,
	output logic                         last_result
);

	logic           fr_valid, fr_ready, bk_valid, bk_ready;
	dbws_pkg::job_t fr_job, bk_job;

	dbws_front #(
		.MAX_BURST (MAX_BURST)
	) u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.opcode              (opcode),
		.now_ns              (now_ns),
		.packet_sequence     (packet_sequence),
		.packet_sender       (packet_sender),
		.acked_number        (acked_number),
		.echoed_send_time_ns (echoed_send_time_ns),
		.cfg_we              (cfg_we),
		.cfg_idx             (cfg_idx),
		.cfg_data            (cfg_data),
		.job_valid           (fr_valid),
		.job_ready           (fr_ready),
		.job                 (fr_job)
	);

	dbws_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_job),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_data  (bk_job)
	);

	dbws_emit u_emit (
		.clk              (clk),
		.arst_n           (arst_n),
		.job_valid        (bk_valid),
		.job_ready        (bk_ready),
		.job              (bk_job),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.out_sequence     (out_sequence),
		.out_send_time_ns (out_send_time_ns),
		.window_now       (window_now),
		.highest_ack      (highest_ack),
		.wait_ns          (wait_ns),
		.roam_event       (roam_event),
		.foreign_sender   (foreign_sender),
		.last_result      (last_result)
	);

	// Only data packets come in bursts
	a_single_non_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != dbws_pkg::KIND_DATA) |-> last_result)
		else $error("non-data result is not the last of its transaction");

	// Non-data results carry no sequence number and no send time
	a_non_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != dbws_pkg::KIND_DATA)
		|-> (out_sequence == 31'd0) && (out_send_time_ns == 63'd0))
		else $error("non-data result carries packet fields");

	// A burst continues in the next cycle with the next sequence number
	a_burst_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (result_kind == dbws_pkg::KIND_DATA) && !last_result
		|=> out_valid && (out_sequence == 31'($past(out_sequence) + 31'd1)))
		else $error("burst sequence broken");

endmodule

`default_nettype wire
